// ===== src/mrfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the memory region free check block.
// No dependencies; used by the core and the checker.
package mrfc_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 64;
    localparam int KIND_W      = 32;

    // Input item: tdata packing, lowest bits first
    localparam int IN_DATA_W   = 4 * ADDR_W + KIND_W;
    localparam int IN_USER_W   = 2;
    // Result item: segment_free, span_low, span_high, append_rejected, region_count
    localparam int OUT_FIELD_W = 1 + 2 * ADDR_W + 1 + CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_AVAIL = KIND_W'(1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_SPAN   = 2'd3
    } cmd_t;

    // One table row; start sits in the low bits, same order as tdata
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/mrfc_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module mrfc_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/memory_region_free_check_core.sv =====
`timescale 1ns / 1ps
// Sequence: clear/append go straight to the result; check/span issue one table read per
// cycle through the RAM port, then read stage, compare stage, drain, result; no reads if empty.
// Throughput: one item at a time; next item accepted the cycle after the result is
// registered, even if the consumer has not taken it yet (the result waits for a free slot).
// Reset: asynchronous, clears the region count and handshake state; table is unset.
// Depends on mrfc_pkg and mrfc_ram.
module memory_region_free_check_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // region_start, region_length, region_kind, query_first, query_last
    input  logic [mrfc_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic [mrfc_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // segment_free, span_low, span_high, append_rejected, region_count
    output logic [mrfc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam int AW = mrfc_pkg::ADDR_W;

    state_t                        state_reg, state_next;
    mrfc_pkg::cmd_t                cmd_reg, cmd_next;
    logic [AW-1:0]                 qa_reg, qa_next;
    logic [AW-1:0]                 qb_reg, qb_next;
    logic [mrfc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          rej_reg, rej_next;
    logic [mrfc_pkg::CNT_W-1:0]    iss_reg, iss_next;
    logic                          rd_v_reg, rd_v_next;
    logic                          s2_v_reg, s2_v_next;
    logic [AW-1:0]                 s2_lo_reg, s2_lo_next;
    logic [AW-1:0]                 s2_hi_reg, s2_hi_next;
    logic                          s2_avail_reg, s2_avail_next;
    logic                          inside_reg, inside_next;
    logic                          hits_reg, hits_next;
    logic [AW-1:0]                 min_reg, min_next;
    logic [AW-1:0]                 max_reg, max_next;
    logic                          m_valid_reg, m_valid_next;
    logic [mrfc_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                          accept;
    logic                          full;
    logic                          issue;
    logic                          ram_we;
    mrfc_pkg::entry_t              ram_rdata;
    logic                          a_in, b_in, lo_in;
    logic                          slot_free;
    logic                          res_free;
    logic [AW-1:0]                 res_low, res_high;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == mrfc_pkg::CNT_W'(mrfc_pkg::TABLE_DEPTH));
    assign ram_we    = accept && (mrfc_pkg::cmd_t'(s_tuser) == mrfc_pkg::CMD_APPEND) && !full;
    assign issue     = (state_reg == ST_SCAN) && (iss_reg != count_reg);
    assign slot_free = !m_valid_reg || m_tready;

    // Appends write only while idle and scans read only after, so no forwarding needed
    mrfc_ram #(
        .WIDTH (mrfc_pkg::ENTRY_W),
        .DEPTH (mrfc_pkg::TABLE_DEPTH),
        .AW    (mrfc_pkg::IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[mrfc_pkg::IDX_W-1:0]),
        .wdata (s_tdata[mrfc_pkg::ENTRY_W-1:0]),
        .re    (issue),
        .raddr (iss_reg[mrfc_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Point tests against the region held in stage 2
    assign a_in  = (qa_reg >= s2_lo_reg) && (qa_reg <= s2_hi_reg);
    assign b_in  = (qb_reg >= s2_lo_reg) && (qb_reg <= s2_hi_reg);
    assign lo_in = (s2_lo_reg >= qa_reg) && (s2_lo_reg <= qb_reg);

    assign res_free = (cmd_reg == mrfc_pkg::CMD_CHECK) && inside_reg && !hits_reg;
    assign res_low  = (cmd_reg == mrfc_pkg::CMD_SPAN) ? min_reg : '0;
    assign res_high = (cmd_reg == mrfc_pkg::CMD_SPAN) ? max_reg : '0;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        qa_next       = qa_reg;
        qb_next       = qb_reg;
        count_next    = count_reg;
        rej_next      = rej_reg;
        iss_next      = iss_reg;
        rd_v_next     = issue;
        s2_v_next     = rd_v_reg;
        s2_lo_next    = ram_rdata.start;
        s2_hi_next    = ram_rdata.start + ram_rdata.length - AW'(1);
        s2_avail_next = (ram_rdata.kind == mrfc_pkg::KIND_AVAIL);
        inside_next   = inside_reg;
        hits_next     = hits_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = mrfc_pkg::cmd_t'(s_tuser);
                    qa_next     = s_tdata[2*AW+mrfc_pkg::KIND_W +: AW];
                    qb_next     = s_tdata[3*AW+mrfc_pkg::KIND_W +: AW];
                    rej_next    = 1'b0;
                    iss_next    = '0;
                    inside_next = 1'b0;
                    hits_next   = 1'b0;
                    min_next    = '1;
                    max_next    = '0;
                    case (mrfc_pkg::cmd_t'(s_tuser))
                        mrfc_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        mrfc_pkg::CMD_APPEND:
                        begin
                            if (full)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + mrfc_pkg::CNT_W'(1);
                            end
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    iss_next = iss_reg + mrfc_pkg::CNT_W'(1);
                end
                if (s2_v_reg)
                begin
                    if (s2_avail_reg)
                    begin
                        if (a_in && b_in)
                        begin
                            inside_next = 1'b1;
                        end
                    end
                    else if (a_in || b_in || lo_in)
                    begin
                        hits_next = 1'b1;
                    end
                    if (s2_lo_reg < min_reg)
                    begin
                        min_next = s2_lo_reg;
                    end
                    if (s2_hi_reg > max_reg)
                    begin
                        max_next = s2_hi_reg;
                    end
                end
                if (!issue && !rd_v_reg && !s2_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = mrfc_pkg::OUT_DATA_W'({count_reg, rej_reg,
                                                          res_high, res_low, res_free});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            cmd_reg      <= mrfc_pkg::CMD_CLEAR;
            qa_reg       <= '0;
            qb_reg       <= '0;
            rej_reg      <= 1'b0;
            iss_reg      <= '0;
            s2_lo_reg    <= '0;
            s2_hi_reg    <= '0;
            s2_avail_reg <= 1'b0;
            inside_reg   <= 1'b0;
            hits_reg     <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
            m_data_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_v_reg     <= rd_v_next;
            s2_v_reg     <= s2_v_next;
            m_valid_reg  <= m_valid_next;
            cmd_reg      <= cmd_next;
            qa_reg       <= qa_next;
            qb_reg       <= qb_next;
            rej_reg      <= rej_next;
            iss_reg      <= iss_next;
            s2_lo_reg    <= s2_lo_next;
            s2_hi_reg    <= s2_hi_next;
            s2_avail_reg <= s2_avail_next;
            inside_reg   <= inside_next;
            hits_reg     <= hits_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            m_data_reg   <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== src/mrfc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for memory_region_free_check_core, plus the bind.
// Depends on mrfc_pkg.
module mrfc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mrfc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int CW = mrfc_pkg::CNT_W;
    localparam int RJ = 2 * mrfc_pkg::ADDR_W + 1;

    // Held result must not change until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A free segment comes only from a check: span fields and reject stay zero
    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[RJ:1] == '0))
        else $error("free flag with span or reject set");

    // A rejected append means the table was full
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[RJ] |->
            (m_tdata[RJ+CW -: CW] == CW'(mrfc_pkg::TABLE_DEPTH)))
        else $error("append rejected with table not full");

    // Count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RJ+CW -: CW] <= CW'(mrfc_pkg::TABLE_DEPTH)))
        else $error("region count out of range");

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted back to back");

endmodule

bind memory_region_free_check_core mrfc_checker u_mrfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
